### rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character constants and the symbol lookup for the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;  // '='
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;  // '/'

  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;

  // number of '=' characters closing a group
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_t;

  // one complete group of up to three bytes, ready to be turned into symbols
  typedef struct packed {
    logic [23:0] bits;
    pad_t        pad;
    logic        fin;
  } grp_t;

  localparam logic [1:0] SYM_THIRD = 2'd2;
  localparam logic [1:0] SYM_LAST  = 2'd3;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < SEXTET_LOWER) begin
      return CHAR_UPPER_A + w;
    end else if (v < SEXTET_DIGIT) begin
      return CHAR_LOWER_A + w - {2'b00, SEXTET_LOWER};
    end else if (v < SEXTET_PLUS) begin
      return CHAR_ZERO + w - {2'b00, SEXTET_DIGIT};
    end else if (v == SEXTET_PLUS) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

### rtl/b64e_if.sv
// ----------------------------------------------------------------------------
// b64e channel interfaces
// Valid/ready channels for raw bytes in and encoded symbols out.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

### rtl/base64_stream_encoder_core.sv
// Order: a group's closing byte is written into the group queue; its first
// symbol then moves into the output register, and the other three follow it.
// Throughput: one byte per cycle in while the queue has room; the single-symbol
// output register sends one symbol per cycle unless stalled, four per group.
// Reset: synchronous, active low; clears the byte count, queue and output valid.
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Byte collector, group queue and symbol emitter of the base64 encoder.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  b64e_byte_if.sink    in_ch,
  b64e_sym_if.source   out_ch
);
  import b64e_pkg::*;

  logic push_valid;
  grp_t push_grp;
  logic push_ready;
  logic head_valid;
  grp_t head_grp;
  logic pop;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_grp   (push_grp),
    .push_ready (push_ready)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_grp   (push_grp),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_grp   (head_grp),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

### rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Collects incoming bytes into groups of three and pushes each closed group,
// full or padded, into the group queue.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic             clk,
  input  logic             rst_n,
  b64e_byte_if.sink        in_ch,
  output logic             push_valid,
  output b64e_pkg::grp_t   push_grp,
  input  logic             push_ready
);
  import b64e_pkg::*;

  typedef enum logic [2:0] {
    CNT_ZERO = 3'b001,
    CNT_ONE  = 3'b010,
    CNT_TWO  = 3'b100
  } cnt_t;

  cnt_t       cnt_r, cnt_nxt;
  logic [7:0] held_first_r, held_first_nxt;
  logic [7:0] held_second_r, held_second_nxt;
  logic       acc;

  assign in_ch.ready = push_ready;
  assign acc         = in_ch.valid && push_ready;

  always_comb begin
    cnt_nxt         = cnt_r;
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    push_valid      = 1'b0;
    push_grp.bits   = {held_first_r, held_second_r, in_ch.data_byte};
    push_grp.pad    = PAD_NONE;
    push_grp.fin    = in_ch.last_byte;
    unique case (cnt_r)
      CNT_ONE: begin
        push_grp.bits = {held_first_r, in_ch.data_byte, 8'h00};
        push_grp.pad  = PAD_ONE;
        if (acc) begin
          held_second_nxt = in_ch.data_byte;
          if (in_ch.last_byte) begin
            push_valid = 1'b1;
            cnt_nxt    = CNT_ZERO;
          end else begin
            cnt_nxt = CNT_TWO;
          end
        end
      end
      CNT_TWO: begin
        if (acc) begin
          push_valid = 1'b1;
          cnt_nxt    = CNT_ZERO;
        end
      end
      default: begin
        // start a new group
        push_grp.bits = {in_ch.data_byte, 16'h0000};
        push_grp.pad  = PAD_TWO;
        if (acc) begin
          held_first_nxt = in_ch.data_byte;
          if (in_ch.last_byte) begin
            push_valid = 1'b1;
            cnt_nxt    = CNT_ZERO;
          end else begin
            cnt_nxt = CNT_ONE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_ZERO;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_first_r  <= held_first_nxt;
    held_second_r <= held_second_nxt;
  end

endmodule

### rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short FIFO of closed groups between the byte collector and the symbol
// emitter.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  b64e_pkg::grp_t   push_grp,
  output logic             push_ready,
  output logic             head_valid,
  output b64e_pkg::grp_t   head_grp,
  input  logic             pop
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_grp   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

### rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head group through its four sextets, one symbol per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  b64e_pkg::grp_t   head_grp,
  output logic             pop,
  b64e_sym_if.source       out_ch
);
  import b64e_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_symbol_r, out_symbol_nxt;
  logic       out_last_r, out_last_nxt;
  logic       load;
  logic [5:0] sextet;
  logic       is_pad;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol      = out_symbol_r;
  assign out_ch.last_symbol = out_last_r;

  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && (idx_r == SYM_LAST);

  always_comb begin
    unique case (idx_r)
      2'd0:    sextet = head_grp.bits[23:18];
      2'd1:    sextet = head_grp.bits[17:12];
      2'd2:    sextet = head_grp.bits[11:6];
      default: sextet = head_grp.bits[5:0];
    endcase
    is_pad = ((idx_r == SYM_LAST) && (head_grp.pad != PAD_NONE)) ||
             ((idx_r == SYM_THIRD) && (head_grp.pad == PAD_TWO));
  end

  always_comb begin
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    if (load) begin
      idx_nxt        = idx_r + 1'b1;
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = is_pad ? PAD_CHAR : b64_char(sextet);
      out_last_nxt   = head_grp.fin && (idx_r == SYM_LAST);
    end else if (out_ch.ready) begin
      // drop the transaction just taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### rtl/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the symbol output of the base64 encoder.
// ----------------------------------------------------------------------------
module b64e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic       out_last
);
  import b64e_pkg::*;

  // a pending transaction holds until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_last))
    else $error("out payload changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid set after reset");

  // a non-final pad is always followed at once by the final pad of the group
  a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_symbol == PAD_CHAR) && !out_last
    |=> out_valid && (out_symbol == PAD_CHAR) && out_last)
    else $error("first pad not followed by closing pad");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_symbol (out_ch.symbol),
  .out_last   (out_ch.last_symbol)
);

### verif/tb_base64_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_core
// Self-checking bench for the base64 stream encoder. A queue of raw bytes,
// grouped into messages, feeds a valid/ready driver. A monitor predicts the
// symbols of every accepted byte and checks each symbol transaction in order.
// Both sides idle at random, except for a stretch in the middle of the run.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_core;
  import b64e_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       hold;  // marker: pause until every symbol has come out
  } byte_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       fin;
  } sym_exp_t;

  logic clk;
  logic rst_n;

  b64e_byte_if byte_ch ();
  b64e_sym_if  sym_ch ();

  base64_stream_encoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (sym_ch)
  );

  byte_item_t pending_bytes[$];
  sym_exp_t   expected_syms[$];
  byte_item_t next_byte;
  int         bytes_taken;
  int         bytes_queued;
  int         errors;

  // encoder state as seen by the predictor
  logic [7:0] grp_first;
  logic [7:0] grp_second;
  logic [1:0] grp_fill;

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  wire calm = (bytes_taken >= 200) && (bytes_taken < 320);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Push four symbols: nsym data sextets from the top of bits, then pads.
  task automatic push_group(input logic [23:0] bits, input int nsym, input logic fin);
    logic [5:0] sx;
    sym_exp_t   s;
    for (int k = 0; k < 4; k++) begin
      sx = bits[23 - 6 * k -: 6];
      s.symbol = (k < nsym) ? b64_alphabet[sx] : PAD_CHAR;
      s.fin = (k == 3) && fin;
      expected_syms.push_back(s);
    end
  endtask

  task automatic predict_symbols(input logic [7:0] b, input logic fin);
    case (grp_fill)
      2'd1: begin
        grp_second = b;
        if (!fin) begin
          grp_fill = 2'd2;
        end else begin
          push_group({grp_first, b, 8'h00}, 3, 1'b1);
          grp_fill = 2'd0;
        end
      end
      2'd2: begin
        push_group({grp_first, grp_second, b}, 4, fin);
        grp_fill = 2'd0;
      end
      default: begin
        grp_first = b;
        if (!fin) begin
          grp_fill = 2'd1;
        end else begin
          push_group({b, 16'h0000}, 2, 1'b1);
          grp_fill = 2'd0;
        end
      end
    endcase
  endtask

  task automatic check_symbol(input logic [7:0] sym, input logic fin);
    sym_exp_t want;
    if (expected_syms.size() == 0) begin
      if (errors < 10) $display("unexpected symbol %h last=%b", sym, fin);
      errors++;
    end else begin
      want = expected_syms.pop_front();
      if (want.symbol !== sym || want.fin !== fin) begin
        if (errors < 10) begin
          $display("symbol mismatch: expected %h last=%b, got %h last=%b",
                   want.symbol, want.fin, sym, fin);
        end
        errors++;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] d, input logic fin);
    byte_item_t it;
    it.data = d;
    it.fin = fin;
    it.hold = 1'b0;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  task automatic add_pause();
    byte_item_t it;
    it = '0;
    it.hold = 1'b1;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic add_message(input int len);
    for (int i = 0; i < len; i++) begin
      add_byte(pick_byte(), i == len - 1);
      // pauses land after any byte: between messages, between groups or inside a partial group
      if (bytes_queued % 157 == 0) add_pause();
    end
  endtask

  // Driver: once the current transaction is taken, offer the next byte, idle at random, or wait at a pause.
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
    end else if (!byte_ch.valid || byte_ch.ready) begin
      if (pending_bytes.size() != 0 && pending_bytes[0].hold) begin
        byte_ch.valid <= 1'b0;
        if (!byte_ch.valid && expected_syms.size() == 0) begin
          void'(pending_bytes.pop_front());
        end
      end else if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
        next_byte = pending_bytes.pop_front();
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= next_byte.data;
        byte_ch.last_byte <= next_byte.fin;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check symbols first, then predict from the byte taken this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      sym_ch.ready <= 1'b0;
    end else begin
      if (sym_ch.valid && sym_ch.ready) begin
        check_symbol(sym_ch.symbol, sym_ch.last_symbol);
      end
      if (byte_ch.valid && byte_ch.ready) begin
        predict_symbols(byte_ch.data_byte, byte_ch.last_byte);
        bytes_taken++;
      end
      sym_ch.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    sym_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    grp_first   = 8'h00;
    grp_second  = 8'h00;
    grp_fill    = 2'd0;
    bytes_taken = 0;
    bytes_queued = 0;
    errors      = 0;

    // one-byte messages, both pads
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    // two-byte messages, one pad
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    // full groups closing a message
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    // full groups inside a message, then a lone closing byte
    add_byte(8'h4D, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h6E, 1'b0);
    add_byte(8'hFB, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hBE, 1'b0);
    add_byte(8'hA5, 1'b1);
    add_pause();

    bytes_queued = 0;
    while (bytes_queued < 480) begin
      if ($urandom_range(14) == 0) add_message($urandom_range(20, 48));
      else add_message($urandom_range(1, 10));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || byte_ch.valid || expected_syms.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (errors == 0 && expected_syms.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
